@@ sv/tdp_pkg.sv @@
// tdp_pkg: shared types and constants for the trajectory difference predictor
// request payload structs, configuration register indexes, state codes
// no dependencies
package tdp_pkg;

  localparam int COORD_WIDTH    = 24;
  localparam int HISTORY_DEPTH  = 10;
  localparam int MAX_HORIZON    = 16;
  localparam int ERR_WIDTH      = 23;
  localparam int STEP_WIDTH     = 4;
  localparam int HORIZON_WIDTH  = 5;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int POS_SHIFT      = 17;  // internal position unit is 2^-17 pixel
  localparam int SQ_WIDTH       = 64;  // sum of squared error terms
  localparam int ERR_MAG_WIDTH  = 31;  // clamp of one error term

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_HORIZON      = 3'd0,
    CFG_LIMIT_X      = 3'd1,
    CFG_LIMIT_Y      = 3'd2,
    CFG_LIMIT_WIDTH  = 3'd3,
    CFG_LIMIT_HEIGHT = 3'd4
  } cfg_idx_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_WALK  = 9'b0_0000_0010,
    S_DRAIN = 9'b0_0000_0100,
    S_PREP  = 9'b0_0000_1000,
    S_DIV   = 9'b0_0001_0000,
    S_ERR   = 9'b0_0010_0000,
    S_SQRT  = 9'b0_0100_0000,
    S_STEP  = 9'b0_1000_0000,
    S_EMIT  = 9'b1_0000_0000
  } state_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          restart;
  } in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pred_x;
    logic signed [COORD_WIDTH-1:0] pred_y;
    logic signed [COORD_WIDTH-1:0] pred_z;
    logic [ERR_WIDTH-1:0]          fit_error;
    logic [STEP_WIDTH-1:0]         step_index;
    logic                          left_limit;
    logic                          last_pred;
  } out_t;

endpackage

@@ sv/trajectory_difference_predictor.sv @@
// one request at a time: the history walk, the bit-serial acceleration divider,
// the error terms and the square root run before the first result, then the
// results follow, one per extrapolation step, each held under back-pressure
// reset: synchronous active low, clears point count, control and config registers
// (horizon 1, rectangle 0); the history memory is not cleared
module trajectory_difference_predictor #(
  parameter int HISTORY_DEPTH = tdp_pkg::HISTORY_DEPTH,
  parameter int MAX_HORIZON   = tdp_pkg::MAX_HORIZON
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tdp_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tdp_pkg::out_t                       out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tdp_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [tdp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  // widths
  localparam int CW     = tdp_pkg::COORD_WIDTH;
  localparam int IW     = $clog2(HISTORY_DEPTH);
  localparam int CNW    = $clog2(HISTORY_DEPTH + 1);
  localparam int DW     = CW + 3;                 // second difference
  localparam int WTW    = CNW + 1;                // weight
  localparam int SUMW   = DW + 2 * CNW;           // weighted sum
  localparam int DIVMAX = HISTORY_DEPTH * (HISTORY_DEPTH - 1) / 2;
  localparam int DVW    = $clog2(DIVMAX + 1);     // divisor
  localparam int NUMW   = SUMW + 8;               // divider dividend magnitude
  localparam int AW     = NUMW + 1;               // half acceleration, signed
  localparam int HW     = $clog2(MAX_HORIZON + 1);
  localparam int PW     = AW + 2 * HW + 2;        // position and velocity
  localparam int EW     = AW + 1;                 // error term before rounding
  localparam int SW     = tdp_pkg::SQ_WIDTH;
  localparam int TW     = SW + 2;                 // three times a root trial
  localparam int MW     = tdp_pkg::ERR_MAG_WIDTH;
  localparam int RW     = tdp_pkg::ERR_WIDTH;
  localparam int PS     = tdp_pkg::POS_SHIFT;
  localparam int CNTW   = 6;
  localparam int ERR_LAST = 4;

  localparam logic [PW-1:0] MAXP = PW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [SW-1:0] RMAX = SW'((64'd1 << RW) - 64'd1);

  tdp_pkg::state_t state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CNW-1:0]  count_r, count_nxt;
  logic [IW-1:0]   wptr_r, wptr_nxt;
  logic            rd_v_r, rd_v_nxt;
  logic [CNW-1:0]  rd_k_r, rd_k_nxt;
  logic [HW-1:0]   step_r, step_nxt;
  logic            load_out;
  logic            in_fire, cfg_fire;

  // configuration
  logic [tdp_pkg::HORIZON_WIDTH-1:0] horizon_r;
  logic signed [15:0]                limx_r, limy_r;
  logic [15:0]                       limw_r, limh_r;

  // history memory, {z, y, x} per entry, newest at wptr_r
  logic [3*CW-1:0] hist_mem [HISTORY_DEPTH];
  logic [3*CW-1:0] mem_q_r;
  logic [IW-1:0]   rd_addr;
  logic [IW:0]     rd_tmp;

  // per-axis lanes
  logic signed [CW-1:0]   h0_r [3];
  logic signed [CW-1:0]   h1_r [3];
  logic signed [CW-1:0]   p0_r [3];
  logic signed [CW-1:0]   p1_r [3];
  logic signed [DW-1:0]   acc3_r [3];
  logic signed [SUMW-1:0] sum_r [3];
  logic                   neg_r [3];
  logic [NUMW-1:0]        num_r [3];
  logic [DVW-1:0]         rem_r [3];
  logic signed [AW-1:0]   a_r [3];
  logic signed [PW-1:0]   pos_r [3];
  logic signed [PW-1:0]   vel_r [3];
  logic [DVW-1:0]         dvs_r;

  logic signed [CW-1:0]     rd_d [3];
  logic signed [DW-1:0]     diff [3];
  logic signed [DW+WTW:0]   prod [3];
  logic [WTW-1:0]           wgt;
  logic [SUMW-1:0]          sum_mag [3];
  logic [NUMW-1:0]          num_init [3];
  logic [DVW:0]             dv_t [3];
  logic                     dv_ge [3];
  logic [DVW-1:0]           rem_n [3];
  logic signed [AW-1:0]     a_val [3];
  logic [2*CNW-1:0]         nn;
  logic [DVW-1:0]           dvs;

  // error path
  logic [1:0]             lidx;
  logic signed [EW-1:0]   e_val;
  logic [EW-1:0]          e_mag, e_rnd;
  logic [MW-1:0]          e_clamp;
  logic [2*MW-1:0]        sq_r;
  logic                   sq_v_r;
  logic [SW-1:0]          ssum_r;
  logic [SW-1:0]          res_r, sq_bit_r, trial;
  logic [TW-1:0]          trial3;
  logic                   sq_ge;

  // extrapolation and output
  logic [HW-1:0]          steps;
  logic signed [PW-1:0]   lx, ly, rx, ry;
  logic                   outside, last;
  logic [PW-1:0]          pmag [3];
  logic [PW-1:0]          rnd [3];
  logic signed [CW-1:0]   pred [3];
  logic [RW-1:0]          fit_err;
  logic                   out_valid_r;
  tdp_pkg::out_t          out_r;

  assign in_ready  = (state_r == tdp_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // read address walks from the newest entry backwards around the ring
  always_comb begin
    if ({1'b0, wptr_r} >= (IW + 1)'(cnt_r)) begin
      rd_tmp = {1'b0, wptr_r} - (IW + 1)'(cnt_r);
    end else begin
      rd_tmp = {1'b0, wptr_r} + (IW + 1)'(HISTORY_DEPTH) - (IW + 1)'(cnt_r);
    end
    rd_addr = rd_tmp[IW-1:0];
  end

  // run length: horizon clamped to the largest supported count
  always_comb begin
    if (int'(horizon_r) > MAX_HORIZON) begin
      steps = HW'(MAX_HORIZON);
    end else begin
      steps = HW'(horizon_r);
    end
  end

  // divisor is one plus the sum of weights, n(n-1)/2 for n of three or more
  always_comb begin
    nn = (2 * CNW)'(count_r) * (2 * CNW)'(count_r - 1'b1);
    if (count_r < CNW'(3)) begin
      dvs = DVW'(1);
    end else begin
      dvs = DVW'(nn >> 1);
    end
  end

  assign wgt = WTW'(count_r) + WTW'(1) - WTW'(rd_k_r);

  // lane arithmetic: second difference, weighted term, restoring divider step
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rd_d[l]     = $signed(mem_q_r[l*CW +: CW]);
      diff[l]     = DW'(p1_r[l]) - (DW'(p0_r[l]) <<< 1) + DW'(rd_d[l]);
      prod[l]     = diff[l] * $signed({1'b0, wgt});
      sum_mag[l]  = sum_r[l][SUMW-1] ? SUMW'(-sum_r[l]) : SUMW'(sum_r[l]);
      num_init[l] = NUMW'({sum_mag[l], 8'b0}) + NUMW'(dvs >> 1);
      dv_t[l]     = {rem_r[l], num_r[l][NUMW-1]};
      dv_ge[l]    = dv_t[l] >= {1'b0, dvs_r};
      rem_n[l]    = dv_ge[l] ? DVW'(dv_t[l] - {1'b0, dvs_r}) : DVW'(dv_t[l]);
      a_val[l]    = neg_r[l] ? -$signed(AW'(num_r[l])) : $signed(AW'(num_r[l]));
    end
  end

  // one error term per cycle: acc3*256 - A in Q.8, rounded to an integer and clamped
  always_comb begin
    lidx    = ((cnt_r >= CNTW'(1)) && (cnt_r <= CNTW'(3))) ? 2'(cnt_r - CNTW'(1)) : 2'd0;
    e_val   = $signed({{(EW - DW - 8){acc3_r[lidx][DW-1]}}, acc3_r[lidx], 8'b0})
              - EW'(a_r[lidx]);
    e_mag   = e_val[EW-1] ? EW'(-e_val) : EW'(e_val);
    e_rnd   = (e_mag + EW'(128)) >> 8;
    e_clamp = (e_rnd > EW'({MW{1'b1}})) ? {MW{1'b1}} : e_rnd[MW-1:0];
  end

  // square root of the sum over three, one bit pair per cycle:
  // a bit is kept when three times the squared candidate still fits the sum
  always_comb begin
    trial  = res_r + sq_bit_r;
    trial3 = TW'(trial) + (TW'(trial) << 1);
    sq_ge  = TW'(ssum_r) >= trial3;
  end

  // rectangle in internal units, rounding and saturation of each coordinate
  always_comb begin
    lx = PW'(limx_r) <<< PS;
    ly = PW'(limy_r) <<< PS;
    rx = (PW'(limx_r) + PW'($signed({1'b0, limw_r}))) <<< PS;
    ry = (PW'(limy_r) + PW'($signed({1'b0, limh_r}))) <<< PS;
    outside = (pos_r[0] < lx) || (pos_r[1] < ly) || (pos_r[0] > rx) || (pos_r[1] > ry);
    last    = outside || (step_r == steps - HW'(1));
    for (int l = 0; l < 3; l++) begin
      pmag[l] = pos_r[l][PW-1] ? PW'(-pos_r[l]) : PW'(pos_r[l]);
      rnd[l]  = (pmag[l] + PW'(256)) >> 9;
      if (!pos_r[l][PW-1]) begin
        pred[l] = (rnd[l] > MAXP) ? CW'(MAXP) : CW'(rnd[l]);
      end else if (rnd[l] > MAXP + PW'(1)) begin
        pred[l] = CW'(-$signed(MAXP) - PW'(1));
      end else begin
        pred[l] = CW'(-$signed(rnd[l]));
      end
    end
    fit_err = (res_r > RMAX) ? RW'(RMAX) : res_r[RW-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    count_nxt = count_r;
    wptr_nxt  = wptr_r;
    rd_v_nxt  = 1'b0;
    rd_k_nxt  = rd_k_r;
    step_nxt  = step_r;
    load_out  = 1'b0;
    unique case (state_r)
      tdp_pkg::S_IDLE: begin
        if (in_fire) begin
          count_nxt = in_data.restart ? CNW'(1) :
                      (count_r == CNW'(HISTORY_DEPTH)) ? count_r : count_r + CNW'(1);
          wptr_nxt  = (wptr_r == IW'(HISTORY_DEPTH - 1)) ? '0 : wptr_r + IW'(1);
          cnt_nxt   = '0;
          state_nxt = tdp_pkg::S_WALK;
        end
      end
      tdp_pkg::S_WALK: begin
        rd_v_nxt = 1'b1;
        rd_k_nxt = CNW'(cnt_r);
        if (CNW'(cnt_r) == count_r - CNW'(1)) begin
          state_nxt = tdp_pkg::S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      tdp_pkg::S_DRAIN: begin
        state_nxt = tdp_pkg::S_PREP;
      end
      tdp_pkg::S_PREP: begin
        cnt_nxt   = '0;
        state_nxt = tdp_pkg::S_DIV;
      end
      tdp_pkg::S_DIV: begin
        if (cnt_r == CNTW'(NUMW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = tdp_pkg::S_ERR;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      tdp_pkg::S_ERR: begin
        if (cnt_r == CNTW'(ERR_LAST)) begin
          cnt_nxt   = '0;
          state_nxt = tdp_pkg::S_SQRT;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      tdp_pkg::S_SQRT: begin
        if (cnt_r == CNTW'(SW / 2 - 1)) begin
          cnt_nxt   = '0;
          step_nxt  = '0;
          state_nxt = (steps == '0) ? tdp_pkg::S_IDLE : tdp_pkg::S_STEP;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      tdp_pkg::S_STEP: begin
        state_nxt = tdp_pkg::S_EMIT;
      end
      tdp_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          load_out = 1'b1;
          if (last) begin
            state_nxt = tdp_pkg::S_IDLE;
          end else begin
            step_nxt  = step_r + HW'(1);
            state_nxt = tdp_pkg::S_STEP;
          end
        end
      end
      default: begin
        state_nxt = tdp_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdp_pkg::S_IDLE;
      cnt_r       <= '0;
      count_r     <= '0;
      wptr_r      <= '0;
      rd_v_r      <= 1'b0;
      rd_k_r      <= '0;
      step_r      <= '0;
      sq_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      horizon_r   <= tdp_pkg::HORIZON_WIDTH'(1);
      limx_r      <= '0;
      limy_r      <= '0;
      limw_r      <= '0;
      limh_r      <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      count_r <= count_nxt;
      wptr_r  <= wptr_nxt;
      rd_v_r  <= rd_v_nxt;
      rd_k_r  <= rd_k_nxt;
      step_r  <= step_nxt;
      sq_v_r  <= (state_r == tdp_pkg::S_ERR) && (cnt_r >= CNTW'(1)) && (cnt_r <= CNTW'(3));
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_fire) begin
        unique case (tdp_pkg::cfg_idx_t'(cfg_index))
          tdp_pkg::CFG_HORIZON:      horizon_r <= cfg_data[tdp_pkg::HORIZON_WIDTH-1:0];
          tdp_pkg::CFG_LIMIT_X:      limx_r    <= $signed(cfg_data);
          tdp_pkg::CFG_LIMIT_Y:      limy_r    <= $signed(cfg_data);
          tdp_pkg::CFG_LIMIT_WIDTH:  limw_r    <= cfg_data;
          tdp_pkg::CFG_LIMIT_HEIGHT: limh_r    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // history memory: one write per request, one registered read per walk cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hist_mem[wptr_nxt] <= {in_data.point_z, in_data.point_y, in_data.point_x};
    end
    if (state_r == tdp_pkg::S_WALK) begin
      mem_q_r <= hist_mem[rd_addr];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    // new request: clear the weighted sums and the three-point acceleration
    if (in_fire) begin
      for (int l = 0; l < 3; l++) begin
        sum_r[l]  <= '0;
        acc3_r[l] <= '0;
      end
    end
    // history walk, newest first; second difference once three points are in
    if (rd_v_r) begin
      for (int l = 0; l < 3; l++) begin
        if (rd_k_r == CNW'(0)) begin
          h0_r[l] <= rd_d[l];
        end
        if (rd_k_r == CNW'(1)) begin
          h1_r[l] <= rd_d[l];
        end
        p0_r[l] <= rd_d[l];
        p1_r[l] <= p0_r[l];
        if (rd_k_r >= CNW'(2)) begin
          sum_r[l] <= sum_r[l] + SUMW'(prod[l]);
        end
        if (rd_k_r == CNW'(2)) begin
          acc3_r[l] <= diff[l];
        end
      end
    end
    case (state_r)
      tdp_pkg::S_PREP: begin
        for (int l = 0; l < 3; l++) begin
          num_r[l] <= num_init[l];
          rem_r[l] <= '0;
          neg_r[l] <= sum_r[l][SUMW-1];
        end
        dvs_r    <= dvs;
        ssum_r   <= '0;
        res_r    <= '0;
        sq_bit_r <= SW'(1) << (SW - 2);
      end
      tdp_pkg::S_DIV: begin
        for (int l = 0; l < 3; l++) begin
          num_r[l] <= {num_r[l][NUMW-2:0], dv_ge[l]};
          rem_r[l] <= rem_n[l];
        end
      end
      tdp_pkg::S_ERR: begin
        // first cycle: latch A and set up the run from the two newest points
        if (cnt_r == '0) begin
          for (int l = 0; l < 3; l++) begin
            a_r[l]   <= a_val[l];
            pos_r[l] <= PW'(h0_r[l]) <<< PS;
            vel_r[l] <= (count_r >= CNW'(2)) ? (PW'(h0_r[l]) - PW'(h1_r[l])) <<< PS : '0;
          end
        end
        sq_r <= e_clamp * e_clamp;
        if (sq_v_r) begin
          ssum_r <= ssum_r + SW'(sq_r);
        end
      end
      tdp_pkg::S_SQRT: begin
        if (sq_ge) begin
          ssum_r <= ssum_r - trial3[SW-1:0];
          res_r  <= (res_r >> 1) + sq_bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      tdp_pkg::S_STEP: begin
        // pos += vel + A, vel += 2A
        for (int l = 0; l < 3; l++) begin
          pos_r[l] <= pos_r[l] + vel_r[l] + PW'(a_r[l]);
          vel_r[l] <= vel_r[l] + (PW'(a_r[l]) <<< 1);
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_r.pred_x     <= pred[0];
      out_r.pred_y     <= pred[1];
      out_r.pred_z     <= pred[2];
      out_r.fit_error  <= fit_err;
      out_r.step_index <= tdp_pkg::STEP_WIDTH'(step_r);
      out_r.left_limit <= outside;
      out_r.last_pred  <= last;
    end
  end

  // an accepted request always starts the history walk
  a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == tdp_pkg::S_WALK))
    else $error("request accepted without starting the walk");

  // memory reads never go past the stored points
  a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (rd_k_r < count_r) && (count_r <= CNW'(HISTORY_DEPTH)))
    else $error("history read beyond stored points");

  // a point outside the rectangle ends the run
  a_outside_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.left_limit) |-> out_data.last_pred)
    else $error("outside point not marked last");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking testbench for trajectory_difference_predictor
// predicts every extrapolated point from its own copy of the point history
// depends on tdp_pkg and trajectory_difference_predictor
module tb;

  // scoreboard: keeps history and registers, predicts each run of results
  class traj_scoreboard;
    longint hist[3][tdp_pkg::HISTORY_DEPTH];
    int     stored;
    int     horizon;
    longint lim_x, lim_y, lim_w, lim_h;
    tdp_pkg::out_t pending_preds[$];
    int     fail_count;

    function new();
      stored = 0;
      horizon = 1;
      lim_x = 0;
      lim_y = 0;
      lim_w = 0;
      lim_h = 0;
      fail_count = 0;
    endfunction

    function void set_reg(tdp_pkg::cfg_idx_t idx, logic [tdp_pkg::CFG_DATA_WIDTH-1:0] v);
      case (idx)
        tdp_pkg::CFG_HORIZON:      horizon = v[tdp_pkg::HORIZON_WIDTH-1:0];
        tdp_pkg::CFG_LIMIT_X:      lim_x = longint'($signed(v));
        tdp_pkg::CFG_LIMIT_Y:      lim_y = longint'($signed(v));
        tdp_pkg::CFG_LIMIT_WIDTH:  lim_w = longint'(v);
        tdp_pkg::CFG_LIMIT_HEIGHT: lim_h = longint'(v);
        default: ;
      endcase
    endfunction

    // division rounded half away from zero, d > 0
    function longint rdiv(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    function longint sat24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function void note_request(tdp_pkg::in_t p);
      longint pos[3], vel[3], hacc[3], acc3[3];
      longint sum, wsum, a, d, lx, ly, rx, ry;
      longint unsigned sq, err, mag;
      int n, nv, steps;
      bit outside;
      tdp_pkg::out_t e;
      if (p.restart) stored = 0;
      for (int i = tdp_pkg::HISTORY_DEPTH - 1; i > 0; i--)
        for (int ax = 0; ax < 3; ax++) hist[ax][i] = hist[ax][i-1];
      hist[0][0] = p.point_x;
      hist[1][0] = p.point_y;
      hist[2][0] = p.point_z;
      if (stored < tdp_pkg::HISTORY_DEPTH) stored++;
      n = stored;
      nv = n - 1;
      sq = 0;
      for (int ax = 0; ax < 3; ax++) begin
        sum = 0;
        wsum = 1;
        pos[ax] = hist[ax][0] * 131072;
        vel[ax] = (n >= 2) ? (hist[ax][0] - hist[ax][1]) * 131072 : 0;
        acc3[ax] = (n >= 3) ? hist[ax][0] - 2 * hist[ax][1] + hist[ax][2] : 0;
        // weight of each second difference falls with its age
        for (int i = 0; i <= nv - 2; i++) begin
          a = hist[ax][i] - 2 * hist[ax][i+1] + hist[ax][i+2];
          sum += a * (nv - i);
          wsum += nv - i;
        end
        hacc[ax] = (n >= 3) ? rdiv(sum * 256, wsum) : 0;
        d = rdiv(acc3[ax] * 256 - hacc[ax], 256);
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483647) d = -64'sd2147483647;
        mag = (d < 0) ? -d : d;
        sq += mag * mag;
      end
      err = floor_sqrt(sq / 3);
      if (err > 8388607) err = 8388607;
      lx = lim_x * 131072;
      ly = lim_y * 131072;
      rx = (lim_x + lim_w) * 131072;
      ry = (lim_y + lim_h) * 131072;
      steps = (horizon > tdp_pkg::MAX_HORIZON) ? tdp_pkg::MAX_HORIZON : horizon;
      for (int i = 0; i < steps; i++) begin
        for (int ax = 0; ax < 3; ax++) begin
          pos[ax] += vel[ax] + hacc[ax];
          vel[ax] += 2 * hacc[ax];
        end
        // rectangle test on the exact position, before rounding
        outside = pos[0] < lx || pos[1] < ly || pos[0] > rx || pos[1] > ry;
        e.pred_x = sat24(rdiv(pos[0], 512));
        e.pred_y = sat24(rdiv(pos[1], 512));
        e.pred_z = sat24(rdiv(pos[2], 512));
        e.fit_error = err;
        e.step_index = i;
        e.left_limit = outside;
        e.last_pred = outside || (i == steps - 1);
        pending_preds = {pending_preds, e};
        if (outside) break;
      end
    endfunction

    function void check_result(tdp_pkg::out_t got);
      tdp_pkg::out_t exp_r;
      if (pending_preds.size() == 0) begin
        $error("unexpected result: pred_x %0d step %0d", got.pred_x, got.step_index);
        fail_count++;
        return;
      end
      exp_r = pending_preds.pop_front();
      if (got.pred_x !== exp_r.pred_x) begin
        $error("pred_x: expected %0d, got %0d", exp_r.pred_x, got.pred_x);
        fail_count++;
      end
      if (got.pred_y !== exp_r.pred_y) begin
        $error("pred_y: expected %0d, got %0d", exp_r.pred_y, got.pred_y);
        fail_count++;
      end
      if (got.pred_z !== exp_r.pred_z) begin
        $error("pred_z: expected %0d, got %0d", exp_r.pred_z, got.pred_z);
        fail_count++;
      end
      if (got.fit_error !== exp_r.fit_error) begin
        $error("fit_error: expected %0d, got %0d", exp_r.fit_error, got.fit_error);
        fail_count++;
      end
      if (got.step_index !== exp_r.step_index) begin
        $error("step_index: expected %0d, got %0d", exp_r.step_index, got.step_index);
        fail_count++;
      end
      if (got.left_limit !== exp_r.left_limit) begin
        $error("left_limit: expected %0d, got %0d", exp_r.left_limit, got.left_limit);
        fail_count++;
      end
      if (got.last_pred !== exp_r.last_pred) begin
        $error("last_pred: expected %0d, got %0d", exp_r.last_pred, got.last_pred);
        fail_count++;
      end
    endfunction
  endclass

  // a setting of all five registers plus the number of random requests under it
  typedef struct {
    int hz;
    int lx;
    int ly;
    int w;
    int h;
    int count;
  } phase_t;

  localparam int DRAIN_CYCLES = 400;  // covers the longest request with no result

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  tdp_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  tdp_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [tdp_pkg::CFG_IDX_WIDTH-1:0]  cfg_index;
  logic [tdp_pkg::CFG_DATA_WIDTH-1:0] cfg_data;

  traj_scoreboard sb = new();
  bit steady;      // no idling on either side while set
  int stall_left;

  // state of the synthetic trajectory used for well-formed requests
  longint tpos[3], tvel[3], tacc[3];

  trajectory_difference_predictor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // gap lengths: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (steady || r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: random back-pressure, and check every accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
        end
      end
    end
  end

  // one request; valid is left high so a back-to-back request keeps it up
  task automatic send_point(tdp_pkg::in_t p);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    sb.note_request(p);
  endtask

  task automatic write_reg(tdp_pkg::cfg_idx_t idx, logic [tdp_pkg::CFG_DATA_WIDTH-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every expected result, then for any request that yields none
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_preds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_phase(phase_t ph);
    write_reg(tdp_pkg::CFG_HORIZON, ph.hz);
    write_reg(tdp_pkg::CFG_LIMIT_X, ph.lx);
    write_reg(tdp_pkg::CFG_LIMIT_Y, ph.ly);
    write_reg(tdp_pkg::CFG_LIMIT_WIDTH, ph.w);
    write_reg(tdp_pkg::CFG_LIMIT_HEIGHT, ph.h);
  endtask

  function automatic longint clamp24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic tdp_pkg::in_t mk_point(longint x, longint y, longint z, bit rs);
    tdp_pkg::in_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    p.restart = rs;
    return p;
  endfunction

  // mostly smooth ballistic paths near the rectangle, some pure noise
  function automatic tdp_pkg::in_t next_point();
    tdp_pkg::in_t p;
    bit fresh;
    if ($urandom_range(0, 4) == 0) begin
      p = mk_point($urandom, $urandom, $urandom, $urandom_range(0, 1));
      return p;
    end
    fresh = ($urandom_range(0, 19) == 0);
    for (int ax = 0; ax < 3; ax++) begin
      if (fresh) begin
        tpos[ax] = $signed($urandom_range(0, 400 * 256)) - 200 * 256;
        tvel[ax] = $signed($urandom_range(0, 10 * 256)) - 5 * 256;
        tacc[ax] = $signed($urandom_range(0, 128)) - 64;
      end else begin
        tvel[ax] += tacc[ax] + $signed($urandom_range(0, 8)) - 4;
        tpos[ax] = clamp24(tpos[ax] + tvel[ax]);
      end
    end
    p = mk_point(tpos[0], tpos[1], tpos[2], fresh);
    return p;
  endfunction

  initial begin
    phase_t phases[6];
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= tdp_pkg::CFG_HORIZON;
    cfg_data  <= '0;
    steady = 1'b0;
    for (int ax = 0; ax < 3; ax++) begin
      tpos[ax] = 0;
      tvel[ax] = 256;
      tacc[ax] = 8;
    end
    // horizon, left, top, width, height, random requests
    phases[0] = '{16, -32768, -32768, 65535, 65535, 90};
    phases[1] = '{0, -100, -100, 200, 200, 15};
    phases[2] = '{31, -100, -100, 200, 200, 110};
    phases[3] = '{5, 32767, 32767, 0, 0, 60};
    phases[4] = '{8, -50, 20, 100, 65535, 110};
    phases[5] = '{1, -300, -300, 600, 600, 110};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults first, then the widest rectangle
    send_point(mk_point(0, 0, 0, 1'b0));
    drain();
    apply_phase(phases[0]);
    // one, two and three stored points
    send_point(mk_point(100, -200, 300, 1'b1));
    send_point(mk_point(356, -456, 300, 1'b0));
    send_point(mk_point(700, -500, 100, 1'b0));
    // coordinate extremes, saturation of the extrapolation
    send_point(mk_point(8388607, 8388607, 8388607, 1'b1));
    send_point(mk_point(8388607, 8388607, 8388607, 1'b0));
    send_point(mk_point(-8388608, -8388608, -8388608, 1'b1));
    send_point(mk_point(-8388608, -8388608, -8388608, 1'b0));
    // alternating extremes give the largest acceleration and error
    for (int i = 0; i < 12; i++) begin
      if (i[0]) send_point(mk_point(8388607, -8388608, 8388607, 1'b0));
      else send_point(mk_point(-8388608, 8388607, -8388608, 1'b0));
    end
    send_point(mk_point(0, 0, 0, 1'b1));

    foreach (phases[k]) begin
      if (k > 0) begin
        drain();
        apply_phase(phases[k]);
      end
      steady = (k == 3);
      for (int i = 0; i < phases[k].count; i++) send_point(next_point());
    end

    drain();
    if (sb.fail_count == 0 && sb.pending_preds.size() == 0) begin
      $display("[trajectory_difference_predictor] OK");
    end else begin
      $display("[trajectory_difference_predictor] ERROR");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("[trajectory_difference_predictor] ERROR");
    $finish;
  end

endmodule
